// ===== src/shaa_pkg.sv =====
package shaa_pkg;

    localparam int MAC_W  = 48;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 9;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_INSERT     = 2'd0;
    localparam t_cmd CMD_DELETE     = 2'd1;
    localparam t_cmd CMD_LOOKUP_IP  = 2'd2;
    localparam t_cmd CMD_LOOKUP_MAC = 2'd3;

    localparam logic REG_SUBNET_BASE = 1'b0;
    localparam logic REG_SUBNET_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

endpackage

// ===== src/subnet_host_address_allocator.sv =====
// Subnet host address allocator.
// Input channel: i_in_valid / o_in_stall carry one command (insert, delete,
// lookup address by MAC, lookup MAC by address) with a MAC and an address.
// Output channel: o_out_valid / i_out_stall return one result per command:
// ok, the granted/freed/found address and, for a lookup by address, the MAC.
// Registers subnet_base (0x0) and subnet_size (0x4) sit on the APB port.
// One command is in flight at a time; o_in_stall is high while it is worked.
// Insert, delete and lookup by MAC walk the binding table one slot per cycle
// through a single compare unit and stop at the first match or at the end of
// the table; an insert first picks a free address. A failed insert skips the
// walk and lookup by address reads one slot. The next transfer can be taken in
// the same cycle as the result is presented.
// After reset the block clears the table, one slot per cycle, with o_in_stall
// high; APB writes are taken throughout.
// A result waits in the output register while i_out_stall is high; the next
// command may be taken meanwhile and holds at its last step until the output
// register frees.
module subnet_host_address_allocator
    import shaa_pkg::*;
#(
    parameter int MAX_HOSTS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [MAC_W-1:0]     i_host_mac,
    input  logic [ADDR_W-1:0]    i_host_addr,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_ok,
    output logic [ADDR_W-1:0]    o_result_addr,
    output logic [MAC_W-1:0]     o_result_mac,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int OW     = $clog2(MAX_HOSTS);
    localparam int CW     = $clog2(MAX_HOSTS + 1);
    localparam int SW     = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int SLOT_W = MAC_W + 1;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_ADDR = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [OW-1:0]     r_pidx, n_pidx;
    logic              r_hit, n_hit;
    logic [OW-1:0]     r_off, n_off;
    logic              r_grant, n_grant;
    logic              r_pop, n_pop;
    logic [OW-1:0]     r_fresh, n_fresh;
    logic [CW-1:0]     r_free_cnt, n_free_cnt;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [SIZE_W-1:0] r_size, n_size;
    logic              r_out_valid, n_out_valid;

    t_cmd              r_cmd;
    logic [MAC_W-1:0]  r_mac;
    logic [ADDR_W-1:0] r_addr;
    logic              r_ok, n_ok;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [MAC_W-1:0]  r_res_mac, n_res_mac;

    logic              in_acc;
    logic              out_free;
    logic              cfg_wr;
    logic [SW-1:0]     size_clamp;
    logic [SW-1:0]     hosts;
    logic [ADDR_W-1:0] diff;
    logic              in_range;
    logic [CW-1:0]     cnt_dec;
    logic              match;
    logic [OW-1:0]     gnt_off;

    logic              slot_we, slot_re;
    logic [OW-1:0]     slot_wa, slot_ra;
    logic [SLOT_W-1:0] slot_wd, slot_rd;
    logic              stk_we, stk_re;
    logic [OW-1:0]     stk_wa, stk_ra;
    logic [OW-1:0]     stk_wd, stk_rd;

    shaa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_HOSTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_we),
        .i_wr_addr (slot_wa),
        .i_wr_data (slot_wd),
        .i_rd_en   (slot_re),
        .i_rd_addr (slot_ra),
        .o_rd_data (slot_rd)
    );

    shaa_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_HOSTS)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_we),
        .i_wr_addr (stk_wa),
        .i_wr_data (stk_wd),
        .i_rd_en   (stk_re),
        .i_rd_addr (stk_ra),
        .o_rd_data (stk_rd)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_SUBNET_SIZE) ? APB_DW'(r_size) : r_base;

    always_comb begin
        size_clamp = SW'(r_size);
        if (size_clamp < SW'(3)) begin
            size_clamp = SW'(3);
        end
        if (size_clamp > SW'(MAX_HOSTS)) begin
            size_clamp = SW'(MAX_HOSTS);
        end
        hosts = size_clamp - SW'(2);
    end

    assign diff     = r_addr - r_base;
    assign in_range = diff < ADDR_W'(MAX_HOSTS);
    assign cnt_dec  = r_free_cnt - CW'(1);
    assign match    = r_pend && slot_rd[MAC_W] && (slot_rd[MAC_W-1:0] == r_mac);
    assign gnt_off  = r_pop ? stk_rd : r_off;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_hit       = r_hit;
        n_off       = r_off;
        n_grant     = r_grant;
        n_pop       = r_pop;
        n_fresh     = r_fresh;
        n_free_cnt  = r_free_cnt;
        n_base      = r_base;
        n_size      = r_size;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_res_addr  = r_res_addr;
        n_res_mac   = r_res_mac;

        slot_we = 1'b0;
        slot_wa = r_idx[OW-1:0];
        slot_wd = '0;
        slot_re = 1'b0;
        slot_ra = r_idx[OW-1:0];
        stk_we  = 1'b0;
        stk_wa  = r_free_cnt[OW-1:0];
        stk_wd  = r_pidx;
        stk_re  = 1'b0;
        stk_ra  = cnt_dec[OW-1:0];

        if (cfg_wr) begin
            if (paddr[2] == REG_SUBNET_BASE) begin
                n_base = pwdata;
            end else begin
                n_size = pwdata[SIZE_W-1:0];
            end
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                slot_we = 1'b1;
                if (r_idx == CW'(MAX_HOSTS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_hit  = 1'b0;
                    case (i_command)
                        CMD_INSERT: begin
                            if (r_free_cnt != '0 && SW'(r_free_cnt) == hosts) begin
                                n_free_cnt = '0;
                                n_fresh    = OW'(1);
                            end
                            n_state = ST_PREP;
                        end
                        CMD_LOOKUP_MAC: n_state = ST_ADDR;
                        default:        n_state = ST_SCAN;
                    endcase
                end
            end
            ST_PREP: begin
                if (SW'(r_fresh) <= hosts) begin
                    n_off   = r_fresh;
                    n_fresh = r_fresh + OW'(1);
                    n_grant = 1'b1;
                    n_pop   = 1'b0;
                    n_state = ST_SCAN;
                end else if (r_free_cnt != '0) begin
                    n_free_cnt = cnt_dec;
                    stk_re     = 1'b1;
                    n_grant    = 1'b1;
                    n_pop      = 1'b1;
                    n_state    = ST_SCAN;
                end else begin
                    n_grant = 1'b0;
                    n_pop   = 1'b0;
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_hit   = 1'b1;
                    n_state = ST_FIN;
                end else if (r_idx == CW'(MAX_HOSTS)) begin
                    n_state = ST_FIN;
                end else begin
                    slot_re = 1'b1;
                    n_pend  = 1'b1;
                    n_pidx  = r_idx[OW-1:0];
                    n_idx   = r_idx + CW'(1);
                end
            end
            ST_ADDR: begin
                slot_ra = diff[OW-1:0];
                slot_re = in_range;
                n_hit   = in_range;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    n_ok        = 1'b0;
                    n_res_addr  = r_base;
                    n_res_mac   = '0;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (r_grant) begin
                                n_ok       = 1'b1;
                                n_res_addr = r_base + ADDR_W'(gnt_off);
                                slot_wa    = gnt_off;
                                slot_wd    = {1'b1, r_mac};
                                slot_we    = !r_hit;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_hit) begin
                                n_ok       = 1'b1;
                                n_res_addr = r_base + ADDR_W'(r_pidx);
                                slot_wa    = r_pidx;
                                slot_we    = 1'b1;
                                if (r_free_cnt < CW'(MAX_HOSTS)) begin
                                    stk_we     = 1'b1;
                                    n_free_cnt = r_free_cnt + CW'(1);
                                end
                            end
                        end
                        CMD_LOOKUP_IP: begin
                            if (r_hit) begin
                                n_ok       = 1'b1;
                                n_res_addr = r_base + ADDR_W'(r_pidx);
                            end
                        end
                        CMD_LOOKUP_MAC: begin
                            if (r_hit && slot_rd[MAC_W]) begin
                                n_ok       = 1'b1;
                                n_res_addr = r_addr;
                                n_res_mac  = slot_rd[MAC_W-1:0];
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_grant     <= 1'b0;
            r_pop       <= 1'b0;
            r_fresh     <= OW'(1);
            r_free_cnt  <= '0;
            r_base      <= '0;
            r_size      <= SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_grant     <= n_grant;
            r_pop       <= n_pop;
            r_fresh     <= n_fresh;
            r_free_cnt  <= n_free_cnt;
            r_base      <= n_base;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_command;
            r_mac  <= i_host_mac;
            r_addr <= i_host_addr;
        end
        r_pidx     <= n_pidx;
        r_off      <= n_off;
        r_ok       <= n_ok;
        r_res_addr <= n_res_addr;
        r_res_mac  <= n_res_mac;
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_result_addr = r_res_addr;
    assign o_result_mac  = r_res_mac;

    a_free_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CW'(MAX_HOSTS))
        else $error("free count above table depth");

    a_fresh_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh != '0)
        else $error("fresh pointer points at network address");

    a_slot_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_we |-> (r_state == ST_CLR || r_state == ST_FIN))
        else $error("table written outside clear or finish");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !r_out_valid)
        else $error("result presented during table clear");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE && r_state != ST_CLR))
        else $error("transfer accepted but no work started");

endmodule

// ===== src/shaa_ram.sv =====
module shaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
